>>> rtl/lpcp_pkg.sv
// lpcp_pkg: shared types and constants of the lidar point projection unit
// payload structs, csr decode codes and fixed-point widths
// no dependencies
`default_nettype none

package lpcp_pkg;

   localparam int DIM_BITS       = 11;
   localparam int COEF_BITS      = 21;
   localparam int EDGE_MARGIN    = 10;
   localparam int NORM_FRAC      = 20;
   localparam int QUO_BITS       = 22;
   localparam int DIV_STAGES     = QUO_BITS / 2;
   localparam int DST_META       = 9;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int SIZE_SHIFT     = 42;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROT_X,
      CSR_ROT_Y,
      CSR_ROT_Z,
      CSR_TRANS,
      CSR_FOCAL,
      CSR_CENTER,
      CSR_RADIAL,
      CSR_TAN_SIZE
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } in_type;

   typedef struct packed {
      logic signed [31:0]  kept_x;
      logic signed [31:0]  kept_y;
      logic signed [31:0]  kept_z;
      logic [DIM_BITS-1:0] pixel_column;
      logic [DIM_BITS-1:0] pixel_row;
   } out_type;

   typedef struct packed {
      logic   valid;
      in_type point;
   } meta_type;

   typedef struct packed {
      logic [2:0][2:0][COEF_BITS-1:0] rot;
      logic [2:0][COEF_BITS-1:0]      trans;
      logic [23:0]                    fx;
      logic [23:0]                    fy;
      logic [23:0]                    cx;
      logic [23:0]                    cy;
      logic [COEF_BITS-1:0]           k1;
      logic [COEF_BITS-1:0]           k2;
      logic [COEF_BITS-1:0]           k3;
      logic [COEF_BITS-1:0]           p1;
      logic [COEF_BITS-1:0]           p2;
      logic [DIM_BITS-1:0]            img_width;
      logic [DIM_BITS-1:0]            img_height;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/lpcp_xform.sv
// lpcp_xform: extrinsic rotation and translation into the camera frame
// two register stages; uses lpcp_pkg
`default_nettype none

module lpcp_xform (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lpcp_pkg::cfg_type  cfg,
   input  wire logic               in_valid,
   input  wire lpcp_pkg::in_type   in_point,
   output lpcp_pkg::meta_type      out_meta,
   output logic signed [35:0]      out_cx,
   output logic signed [35:0]      out_cy,
   output logic signed [35:0]      out_cz
);

   lpcp_pkg::meta_type meta1_ff, meta1_in, meta2_ff, meta2_in;
   logic signed [52:0] prod_ff [3][3];
   logic signed [52:0] prod_in [3][3];
   logic signed [38:0] trans_ff [3];
   logic signed [38:0] trans_in [3];
   logic signed [31:0] pt [3];
   logic signed [53:0] acc [3];
   logic signed [35:0] cam_ff [3];
   logic signed [35:0] cam_in [3];

   // stage 1: nine coefficient products
   always_comb begin
      pt[0] = in_point.point_x;
      pt[1] = in_point.point_y;
      pt[2] = in_point.point_z;
      meta1_in.valid = in_valid;
      meta1_in.point = in_point;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[j][k] = $signed(cfg.rot[j][k]) * pt[k];
         end
         trans_in[j] = {cfg.trans[j], 18'b0};
      end
   end

   // stage 2: sum and floor to q.16, drop points behind the camera
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         acc[j] = prod_ff[j][0] + prod_ff[j][1] + prod_ff[j][2] + trans_ff[j];
         cam_in[j] = acc[j][53:18];
      end
      meta2_in.valid = meta1_ff.valid & (cam_in[2] > 0);
      meta2_in.point = meta1_ff.point;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta1_ff.valid <= 1'b0;
         meta2_ff.valid <= 1'b0;
      end else begin
         meta1_ff.valid <= meta1_in.valid;
         meta2_ff.valid <= meta2_in.valid;
      end
      meta1_ff.point <= meta1_in.point;
      meta2_ff.point <= meta2_in.point;
      prod_ff  <= prod_in;
      trans_ff <= trans_in;
      cam_ff   <= cam_in;
   end

   assign out_meta = meta2_ff;
   assign out_cx   = cam_ff[0];
   assign out_cy   = cam_ff[1];
   assign out_cz   = cam_ff[2];

endmodule

`default_nettype wire

>>> rtl/lpcp_div.sv
// lpcp_div: pipelined restoring divider giving normalized x and y in q.20
// one prep stage then two quotient bits per stage; uses lpcp_pkg
`default_nettype none

module lpcp_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lpcp_pkg::meta_type  in_meta,
   input  wire logic signed [35:0]  in_cx,
   input  wire logic signed [35:0]  in_cy,
   input  wire logic signed [35:0]  in_cz,
   output lpcp_pkg::meta_type       out_meta,
   output logic signed [22:0]       out_nx,
   output logic signed [22:0]       out_ny
);

   typedef struct packed {
      logic                          neg;
      logic                          sat;
      logic [34:0]                   rem;
      logic [lpcp_pkg::QUO_BITS-1:0] quo;
      logic [lpcp_pkg::QUO_BITS-1:0] dvd;
   } lane_type;

   typedef struct packed {
      lpcp_pkg::meta_type meta;
      logic [34:0]        den;
      lane_type [1:0]     lane;
   } stage_type;

   stage_type stage_ff [lpcp_pkg::DIV_STAGES+1];
   stage_type stage_in [lpcp_pkg::DIV_STAGES+1];

   function automatic logic [35:0] div_step(input logic [34:0] rem, input logic [34:0] den,
                                            input logic b);
      logic [35:0] r2;
      logic [35:0] res;
      r2 = {rem, b};
      if (r2 >= {1'b0, den}) begin
         res = {1'b1, 35'(r2 - {1'b0, den})};
      end else begin
         res = {1'b0, r2[34:0]};
      end
      return res;
   endfunction

   always_comb begin
      logic signed [35:0] cin [2];
      logic [35:0]        mag;
      logic [35:0]        st;
      lane_type           ln;
      cin[0] = in_cx;
      cin[1] = in_cy;
      // prep: magnitude, saturation when |c| >= 4*cz
      stage_in[0].meta = in_meta;
      stage_in[0].den  = in_cz[34:0];
      for (int l = 0; l < 2; l++) begin
         mag = cin[l][35] ? 36'(-cin[l]) : 36'(cin[l]);
         ln.neg = cin[l][35];
         ln.sat = {2'b0, mag[34:0]} >= {in_cz[34:0], 2'b0};
         ln.rem = {2'b0, mag[34:2]};
         ln.quo = '0;
         ln.dvd = {mag[1:0], {lpcp_pkg::NORM_FRAC{1'b0}}};
         stage_in[0].lane[l] = ln;
      end
      // quotient stages
      for (int s = 1; s <= lpcp_pkg::DIV_STAGES; s++) begin
         stage_in[s] = stage_ff[s-1];
         for (int l = 0; l < 2; l++) begin
            ln = stage_ff[s-1].lane[l];
            for (int b = 0; b < 2; b++) begin
               st = div_step(ln.rem, stage_ff[s-1].den, ln.dvd[lpcp_pkg::QUO_BITS-1]);
               ln.rem = st[34:0];
               ln.quo = {ln.quo[lpcp_pkg::QUO_BITS-2:0], st[35]};
               ln.dvd = {ln.dvd[lpcp_pkg::QUO_BITS-2:0], 1'b0};
            end
            stage_in[s].lane[l] = ln;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= lpcp_pkg::DIV_STAGES; s++) begin
         if (reset) begin
            stage_ff[s].meta.valid <= 1'b0;
         end else begin
            stage_ff[s].meta.valid <= stage_in[s].meta.valid;
         end
         stage_ff[s].meta.point <= stage_in[s].meta.point;
         stage_ff[s].den        <= stage_in[s].den;
         stage_ff[s].lane       <= stage_in[s].lane;
      end
   end

   always_comb begin
      logic [lpcp_pkg::QUO_BITS-1:0] q [2];
      lane_type                      ln;
      for (int l = 0; l < 2; l++) begin
         ln   = stage_ff[lpcp_pkg::DIV_STAGES].lane[l];
         q[l] = ln.sat ? '1 : ln.quo;
      end
      ln = stage_ff[lpcp_pkg::DIV_STAGES].lane[0];
      out_nx = ln.neg ? -$signed({1'b0, q[0]}) : $signed({1'b0, q[0]});
      ln = stage_ff[lpcp_pkg::DIV_STAGES].lane[1];
      out_ny = ln.neg ? -$signed({1'b0, q[1]}) : $signed({1'b0, q[1]});
   end

   assign out_meta = stage_ff[lpcp_pkg::DIV_STAGES].meta;

endmodule

`default_nettype wire

>>> rtl/lpcp_distort.sv
// lpcp_distort: radial and tangential distortion, intrinsics and edge check
// ten register stages, last one is the result register; uses lpcp_pkg
`default_nettype none

module lpcp_distort (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lpcp_pkg::cfg_type   cfg,
   input  wire lpcp_pkg::meta_type  in_meta,
   input  wire logic signed [22:0]  in_nx,
   input  wire logic signed [22:0]  in_ny,
   output logic                     out_valid,
   output lpcp_pkg::out_type        out_result
);

   lpcp_pkg::meta_type meta_ff [lpcp_pkg::DST_META];

   // d1
   logic signed [22:0] x1_ff, y1_ff;
   logic signed [45:0] xxp_ff, yyp_ff, xyp_ff;
   // d2
   logic signed [22:0] x2_ff, y2_ff;
   logic [23:0]        xx2_ff, yy2_ff;
   logic signed [25:0] xy2_ff;
   logic [24:0]        r22_ff;
   logic [44:0]        rsq;
   // d3
   logic signed [22:0] x3_ff, y3_ff;
   logic signed [25:0] xy3_ff;
   logic [24:0]        r23_ff;
   logic [29:0]        r43_ff;
   logic [25:0]        tbx3_ff, tby3_ff;
   logic [49:0]        r4p;
   // d4
   logic signed [22:0] x4_ff, y4_ff;
   logic [34:0]        r64_ff;
   logic signed [46:0] k1r2_ff, p1xy_ff, p2xy_ff;
   logic signed [51:0] k2r4_ff;
   logic signed [47:0] p2tx_ff, p1ty_ff;
   logic [54:0]        r6p;
   // d5
   logic signed [22:0] x5_ff, y5_ff;
   logic signed [46:0] k1r25_ff;
   logic signed [51:0] k2r45_ff;
   logic signed [56:0] k3r6_ff;
   logic signed [31:0] tanx5_ff, tany5_ff;
   logic signed [49:0] tsx, tsy;
   // d6
   logic signed [22:0] x6_ff, y6_ff;
   logic signed [31:0] tanx6_ff, tany6_ff;
   logic signed [41:0] radial_ff;
   logic signed [58:0] rsum;
   logic signed [40:0] rfl;
   // d7
   logic signed [64:0] mx_ff, my_ff;
   logic signed [31:0] tanx7_ff, tany7_ff;
   // d8
   logic signed [32:0] xd_ff, yd_ff;
   logic signed [45:0] xdf, ydf;
   logic signed [44:0] mxs, mys;
   // d9
   logic signed [57:0] fxd_ff, fyd_ff;
   // d10
   logic signed [58:0] su, sv;
   logic signed [27:0] ucol, vrow, ulim, vlim, marg;
   logic               keep;
   logic               out_valid_ff;
   lpcp_pkg::out_type  out_ff, out_in;

   localparam logic signed [45:0] DIST_HI = 46'sd2147483648;
   localparam logic signed [45:0] DIST_LO = -46'sd2147483648;

   always_comb begin
      rsq  = {1'b0, xxp_ff[43:0]} + {1'b0, yyp_ff[43:0]};
      r4p  = r22_ff * r22_ff;
      r6p  = r43_ff * r23_ff;
      tsx  = (p1xy_ff <<< 1) + p2tx_ff;
      tsy  = (p2xy_ff <<< 1) + p1ty_ff;
      rsum = k1r25_ff + k2r45_ff + k3r6_ff;
      rfl  = rsum[58:18];
      mxs  = mx_ff[64:20];
      mys  = my_ff[64:20];
      xdf  = mxs + tanx7_ff;
      ydf  = mys + tany7_ff;
      su   = fxd_ff + $signed({1'b0, cfg.cx, 20'b0});
      sv   = fyd_ff + $signed({1'b0, cfg.cy, 20'b0});
      ucol = $signed({1'b0, su[58:32]});
      vrow = $signed({1'b0, sv[58:32]});
      marg = $signed(28'(lpcp_pkg::EDGE_MARGIN));
      ulim = $signed({{(28-lpcp_pkg::DIM_BITS){1'b0}}, cfg.img_width}) - marg;
      vlim = $signed({{(28-lpcp_pkg::DIM_BITS){1'b0}}, cfg.img_height}) - marg;
      // negative sums are rejected by the sign bit checks on su and sv
      keep = (meta_ff[lpcp_pkg::DST_META-1].point.point_x > 0)
           && !su[58] && (ucol >= marg) && (ucol < ulim)
           && !sv[58] && (vrow >= marg) && (vrow < vlim);
      out_in.kept_x       = meta_ff[lpcp_pkg::DST_META-1].point.point_x;
      out_in.kept_y       = meta_ff[lpcp_pkg::DST_META-1].point.point_y;
      out_in.kept_z       = meta_ff[lpcp_pkg::DST_META-1].point.point_z;
      out_in.pixel_column = su[32 +: lpcp_pkg::DIM_BITS];
      out_in.pixel_row    = sv[32 +: lpcp_pkg::DIM_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < lpcp_pkg::DST_META; s++) begin
            meta_ff[s].valid <= 1'b0;
         end
      end else begin
         meta_ff[0].valid <= in_meta.valid;
         for (int s = 1; s < lpcp_pkg::DST_META; s++) begin
            meta_ff[s].valid <= meta_ff[s-1].valid;
         end
      end
      meta_ff[0].point <= in_meta.point;
      for (int s = 1; s < lpcp_pkg::DST_META; s++) begin
         meta_ff[s].point <= meta_ff[s-1].point;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= meta_ff[lpcp_pkg::DST_META-1].valid & keep;
      end
      out_ff <= out_in;

      // d1: squares and cross product
      x1_ff  <= in_nx;
      y1_ff  <= in_ny;
      xxp_ff <= in_nx * in_nx;
      yyp_ff <= in_ny * in_ny;
      xyp_ff <= in_nx * in_ny;
      // d2: back to q.20
      x2_ff  <= x1_ff;
      y2_ff  <= y1_ff;
      xx2_ff <= xxp_ff[43:20];
      yy2_ff <= yyp_ff[43:20];
      xy2_ff <= xyp_ff[45:20];
      r22_ff <= rsq[44:20];
      // d3: r^4, tangential bases
      x3_ff   <= x2_ff;
      y3_ff   <= y2_ff;
      xy3_ff  <= xy2_ff;
      r23_ff  <= r22_ff;
      r43_ff  <= r4p[49:20];
      tbx3_ff <= {1'b0, r22_ff} + {1'b0, xx2_ff, 1'b0};
      tby3_ff <= {1'b0, r22_ff} + {1'b0, yy2_ff, 1'b0};
      // d4: r^6 and coefficient products
      x4_ff   <= x3_ff;
      y4_ff   <= y3_ff;
      r64_ff  <= r6p[54:20];
      k1r2_ff <= $signed(cfg.k1) * $signed({1'b0, r23_ff});
      k2r4_ff <= $signed(cfg.k2) * $signed({1'b0, r43_ff});
      p1xy_ff <= $signed(cfg.p1) * xy3_ff;
      p2xy_ff <= $signed(cfg.p2) * xy3_ff;
      p2tx_ff <= $signed(cfg.p2) * $signed({1'b0, tbx3_ff});
      p1ty_ff <= $signed(cfg.p1) * $signed({1'b0, tby3_ff});
      // d5: k3 term, tangential offsets
      x5_ff    <= x4_ff;
      y5_ff    <= y4_ff;
      k1r25_ff <= k1r2_ff;
      k2r45_ff <= k2r4_ff;
      k3r6_ff  <= $signed(cfg.k3) * $signed({1'b0, r64_ff});
      tanx5_ff <= tsx[49:18];
      tany5_ff <= tsy[49:18];
      // d6: radial factor
      x6_ff     <= x5_ff;
      y6_ff     <= y5_ff;
      tanx6_ff  <= tanx5_ff;
      tany6_ff  <= tany5_ff;
      radial_ff <= rfl + 42'sd1048576;
      // d7: scale by radial factor
      mx_ff    <= x6_ff * radial_ff;
      my_ff    <= y6_ff * radial_ff;
      tanx7_ff <= tanx6_ff;
      tany7_ff <= tany6_ff;
      // d8: distorted coordinates, saturated
      xd_ff <= (xdf > DIST_HI) ? 33'(DIST_HI) : (xdf < DIST_LO) ? 33'(DIST_LO) : 33'(xdf);
      yd_ff <= (ydf > DIST_HI) ? 33'(DIST_HI) : (ydf < DIST_LO) ? 33'(DIST_LO) : 33'(ydf);
      // d9: focal scaling
      fxd_ff <= $signed({1'b0, cfg.fx}) * xd_ff;
      fyd_ff <= $signed({1'b0, cfg.fy}) * yd_ff;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

`default_nettype wire

>>> rtl/lidar_point_camera_projection_unit.sv
// lidar_point_camera_projection_unit: lidar point to camera pixel, pinhole with distortion
// the strobe follows the accepting edge through 24 register stages; one point per cycle
// busy never rises: the pipe has no stall points and the receiver takes every result
// reset (synchronous, active high) clears csr registers and all valid bits
// uses lpcp_pkg, lpcp_xform, lpcp_div, lpcp_distort
`default_nettype none

module lidar_point_camera_projection_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // command side
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire lpcp_pkg::in_type                       req_point,
   // result side, one cycle strobe
   output logic                                        rsp_valid,
   output lpcp_pkg::out_type                           rsp_result,
   // csr write port
   input  wire logic                                   csr_we,
   input  wire logic [lpcp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [lpcp_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   lpcp_pkg::cfg_type  cfg_ff, cfg_in;
   lpcp_pkg::meta_type xf_meta, dv_meta;
   logic signed [35:0] cam_x, cam_y, cam_z;
   logic signed [22:0] norm_x, norm_y;
   logic               accept;

   // every cycle can take a point
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // csr decode: fields are unpacked once here so the datapath sees plain values
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lpcp_pkg::CSR_ROT_X: begin
               for (int k = 0; k < 3; k++) begin
                  cfg_in.rot[0][k] = csr_wdata[k*lpcp_pkg::COEF_BITS +: lpcp_pkg::COEF_BITS];
               end
            end
            lpcp_pkg::CSR_ROT_Y: begin
               for (int k = 0; k < 3; k++) begin
                  cfg_in.rot[1][k] = csr_wdata[k*lpcp_pkg::COEF_BITS +: lpcp_pkg::COEF_BITS];
               end
            end
            lpcp_pkg::CSR_ROT_Z: begin
               for (int k = 0; k < 3; k++) begin
                  cfg_in.rot[2][k] = csr_wdata[k*lpcp_pkg::COEF_BITS +: lpcp_pkg::COEF_BITS];
               end
            end
            lpcp_pkg::CSR_TRANS: begin
               for (int k = 0; k < 3; k++) begin
                  cfg_in.trans[k] = csr_wdata[k*lpcp_pkg::COEF_BITS +: lpcp_pkg::COEF_BITS];
               end
            end
            lpcp_pkg::CSR_FOCAL: begin
               cfg_in.fx = csr_wdata[23:0];
               cfg_in.fy = csr_wdata[47:24];
            end
            lpcp_pkg::CSR_CENTER: begin
               cfg_in.cx = csr_wdata[23:0];
               cfg_in.cy = csr_wdata[47:24];
            end
            lpcp_pkg::CSR_RADIAL: begin
               cfg_in.k1 = csr_wdata[20:0];
               cfg_in.k2 = csr_wdata[41:21];
               cfg_in.k3 = csr_wdata[62:42];
            end
            lpcp_pkg::CSR_TAN_SIZE: begin
               cfg_in.p1        = csr_wdata[20:0];
               cfg_in.p2        = csr_wdata[41:21];
               cfg_in.img_width = csr_wdata[lpcp_pkg::SIZE_SHIFT +: lpcp_pkg::DIM_BITS];
               // height takes the top bits of the word, 63:53
               cfg_in.img_height = lpcp_pkg::DIM_BITS'(csr_wdata >>
                                   (lpcp_pkg::SIZE_SHIFT + lpcp_pkg::DIM_BITS));
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // camera frame: 2 stages
   lpcp_xform u_xform (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (accept),
      .in_point (req_point),
      .out_meta (xf_meta),
      .out_cx   (cam_x),
      .out_cy   (cam_y),
      .out_cz   (cam_z)
   );

   // perspective divide: 12 stages, two quotient bits per stage
   lpcp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_meta  (xf_meta),
      .in_cx    (cam_x),
      .in_cy    (cam_y),
      .in_cz    (cam_z),
      .out_meta (dv_meta),
      .out_nx   (norm_x),
      .out_ny   (norm_y)
   );

   // distortion, intrinsics and edge check: 10 stages, last is the result register
   lpcp_distort u_distort (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_meta    (dv_meta),
      .in_nx      (norm_x),
      .in_ny      (norm_y),
      .out_valid  (rsp_valid),
      .out_result (rsp_result)
   );

   // a transfer right after reset is impossible: all valid bits are cleared
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   // kept points always lie at or past the margin from the low column and row edges
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result.pixel_column >= lpcp_pkg::DIM_BITS'(lpcp_pkg::EDGE_MARGIN))
      else $error("column inside edge margin");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result.pixel_row >= lpcp_pkg::DIM_BITS'(lpcp_pkg::EDGE_MARGIN))
      else $error("row inside edge margin");

   // only points ahead of the sensor are passed on
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result.kept_x > 0)
      else $error("kept point with non-positive x");

endmodule

`default_nettype wire
